// ----- rtl/mqe_pkg.sv -----
`timescale 1ns / 1ps

package mqe_pkg;

  localparam int DELTA_W    = 8;
  localparam int SCALE_W    = 16;
  localparam int STEPS_W    = 8;
  localparam int PERIOD_W   = 20;
  localparam int PROD_W     = STEPS_W + SCALE_W;

  localparam logic [PERIOD_W-1:0] PERIOD_MAX  = {PERIOD_W{1'b1}};
  localparam logic [SCALE_W-1:0]  SCALE_RESET = SCALE_W'(256);

  // largest magnitude times largest scale
  localparam int MAX_DEN = (1 << (DELTA_W - 1)) * ((1 << SCALE_W) - 1);

  localparam int DEF_FULL_SCALE_TICKS = 128;
  localparam int DEF_IDLE_TICKS       = 750000;

  typedef enum logic {
    OP_REPORT = 1'b0,
    OP_TICK   = 1'b1
  } opcode_t;

  typedef struct packed {
    opcode_t                    opcode;
    logic signed [DELTA_W-1:0]  delta_x;
    logic signed [DELTA_W-1:0]  delta_y;
  } in_t;

  typedef struct packed {
    logic x_line_a;
    logic x_line_b;
    logic y_line_a;
    logic y_line_b;
  } out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_PREP,
    ST_DIV,
    ST_STORE,
    ST_TICK,
    ST_FIN
  } state_t;

  // quadrature levels: phase 0..3 gives a = 0,1,1,0 and b = 0,0,1,1
  function automatic logic line_a(input logic [1:0] ph);
    return ph[0] ^ ph[1];
  endfunction

  function automatic logic line_b(input logic [1:0] ph);
    return ph[1];
  endfunction

endpackage

// ----- rtl/mouse_quadrature_emulator_top.sv -----
`timescale 1ns / 1ps
// sequence: a tick runs the TICK and FIN states; a report runs SETUP for each axis and
//   PREP, DIV and STORE on the shared divider for each axis with a nonzero product, then FIN
// throughput: one item at a time, and FIN waits until the output register can take the result;
//   in_ready is high only while the sequencer idles,
//   and a finished result waits in the output register while the next item is taken
// reset: synchronous active-high rst clears phases and step counts, loads the idle
//   period into both axes and sets scale to 1.0
module mouse_quadrature_emulator_top #(
  parameter int FULL_SCALE_TICKS = mqe_pkg::DEF_FULL_SCALE_TICKS,
  parameter int IDLE_TICKS       = mqe_pkg::DEF_IDLE_TICKS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  mqe_pkg::in_t                 in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output mqe_pkg::out_t                out_data,
  input  logic                         cfg_we,
  input  logic [mqe_pkg::SCALE_W-1:0]  cfg_data
);
  import mqe_pkg::*;

  // numerator of the period: full-scale ticks in 8.8 units
  localparam int NUM = FULL_SCALE_TICKS * 256;
  // dividend is 2*NUM + den, divisor is 2*den; both fit DW bits
  localparam int DW  = $clog2(2 * NUM + MAX_DEN + 1);
  localparam int CW  = $clog2(DW + 1);

  localparam logic [PERIOD_W-1:0] IDLE_PERIOD = PERIOD_W'(IDLE_TICKS);
  localparam logic [DW-1:0]       TWO_NUM     = DW'(2 * NUM);

  state_t state, state_next;

  // configuration
  logic [SCALE_W-1:0] scale;

  // latched report deltas, y already negated
  logic signed [DELTA_W:0] delta0, delta1;
  logic                    ax;

  // per-axis state
  logic [STEPS_W-1:0]  steps   [2];
  logic                negdir  [2];
  logic [1:0]          phase   [2];
  logic [PERIOD_W-1:0] period  [2];
  logic [PERIOD_W-1:0] cdown   [2];

  // shared multiply / divide unit
  logic [PROD_W-1:0] prod;
  logic [DW-1:0]     rem;
  logic [DW-1:0]     dvd;
  logic [DW-1:0]     dsr;
  logic [CW-1:0]     cnt;

  logic in_xfer;
  logic slot_free;

  // current axis delta, magnitude and sign
  logic signed [DELTA_W:0] cur_delta;
  logic [DELTA_W:0]        cur_mag9;
  logic [STEPS_W-1:0]      cur_mag;
  logic                    cur_neg;
  logic                    cur_zero;

  // one restoring divide step
  logic [DW:0]         rem_sh;
  logic                q_bit;
  logic [DW-1:0]       rem_step;
  logic [PERIOD_W-1:0] quot;

  assign in_xfer   = in_valid && in_ready;
  assign slot_free = !out_valid || out_ready;

  always_comb begin
    cur_delta = ax ? delta1 : delta0;
    cur_neg   = cur_delta[DELTA_W];
    cur_zero  = (cur_delta == '0);
    cur_mag9  = cur_neg ? (DELTA_W+1)'(-cur_delta) : cur_delta;
    cur_mag   = cur_mag9[STEPS_W-1:0];
  end

  always_comb begin
    rem_sh   = {rem, dvd[DW-1]};
    q_bit    = (rem_sh >= {1'b0, dsr});
    rem_step = q_bit ? DW'(rem_sh - {1'b0, dsr}) : rem_sh[DW-1:0];
    quot     = dvd[PERIOD_W-1:0];
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_xfer) begin
          state_next = (in_data.opcode == OP_TICK) ? ST_TICK : ST_SETUP;
        end
      end
      ST_SETUP: begin
        if (cur_zero) begin
          state_next = ax ? ST_FIN : ST_SETUP;
        end else begin
          state_next = ST_PREP;
        end
      end
      ST_PREP: begin
        if (prod == '0) begin
          state_next = ax ? ST_FIN : ST_SETUP;
        end else begin
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (cnt == CW'(1)) begin
          state_next = ST_STORE;
        end
      end
      ST_STORE: state_next = ax ? ST_FIN : ST_SETUP;
      ST_TICK:  state_next = ST_FIN;
      ST_FIN: begin
        if (slot_free) begin
          state_next = ST_IDLE;
        end
      end
      default:  state_next = ST_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    in_ready = (state == ST_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      ax        <= 1'b0;
      out_valid <= 1'b0;
      scale     <= SCALE_RESET;
      for (int i = 0; i < 2; i++) begin
        steps[i]  <= '0;
        negdir[i] <= 1'b0;
        phase[i]  <= '0;
        period[i] <= IDLE_PERIOD;
        cdown[i]  <= IDLE_PERIOD;
      end
    end else begin
      state <= state_next;

      if (cfg_we) begin
        scale <= cfg_data;
      end

      // a new result loads the register when it is empty or as the old one leaves
      if (state == ST_FIN && slot_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (in_xfer) begin
            delta0 <= (DELTA_W+1)'(in_data.delta_x);
            delta1 <= (DELTA_W+1)'(-((DELTA_W+1)'(in_data.delta_y)));
            ax     <= 1'b0;
          end
        end
        ST_SETUP: begin
          if (cur_zero) begin
            // zero delta: idle period, steps and direction kept
            period[ax] <= IDLE_PERIOD;
            cdown[ax]  <= IDLE_PERIOD;
            ax         <= 1'b1;
          end else begin
            steps[ax]  <= cur_mag;
            negdir[ax] <= cur_neg;
            prod       <= PROD_W'(cur_mag) * PROD_W'(scale);
          end
        end
        ST_PREP: begin
          if (prod == '0) begin
            // zero scale saturates the period
            period[ax] <= PERIOD_MAX;
            cdown[ax]  <= PERIOD_MAX;
            ax         <= 1'b1;
          end else begin
            rem <= '0;
            dvd <= TWO_NUM + DW'(prod);
            dsr <= DW'({prod, 1'b0});
            cnt <= CW'(DW);
          end
        end
        ST_DIV: begin
          rem <= rem_step;
          dvd <= {dvd[DW-2:0], q_bit};
          cnt <= cnt - CW'(1);
        end
        ST_STORE: begin
          // quotient never exceeds NUM, floor at one
          period[ax] <= (quot == '0) ? PERIOD_W'(1) : quot;
          cdown[ax]  <= (quot == '0) ? PERIOD_W'(1) : quot;
          ax         <= 1'b1;
        end
        ST_TICK: begin
          for (int i = 0; i < 2; i++) begin
            if (cdown[i] <= PERIOD_W'(1)) begin
              cdown[i] <= period[i];
              if (steps[i] != '0) begin
                steps[i] <= steps[i] - STEPS_W'(1);
                phase[i] <= negdir[i] ? phase[i] - 2'd1 : phase[i] + 2'd1;
              end
            end else begin
              cdown[i] <= cdown[i] - PERIOD_W'(1);
            end
          end
        end
        ST_FIN: begin
          if (slot_free) begin
            out_data.x_line_a <= line_a(phase[0]);
            out_data.x_line_b <= line_b(phase[0]);
            out_data.y_line_a <= line_a(phase[1]);
            out_data.y_line_b <= line_b(phase[1]);
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/mqe_checker.sv -----
`timescale 1ns / 1ps
module mqe_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input mqe_pkg::out_t               out_data
);
  import mqe_pkg::*;

  logic       have_last;
  logic [1:0] last_x;
  logic [1:0] last_y;
  logic       out_xfer;

  assign out_xfer = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      have_last <= 1'b0;
    end else if (out_xfer) begin
      have_last <= 1'b1;
      last_x    <= {out_data.x_line_a, out_data.x_line_b};
      last_y    <= {out_data.y_line_a, out_data.y_line_b};
    end
  end

  // one item at a time
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again right after a transfer");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("pending result dropped or changed");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

  // gray-coded lines: an axis never jumps two phases between results
  a_gray_step: assert property (@(posedge clk) disable iff (rst)
    out_xfer && have_last |->
      $countones(last_x ^ {out_data.x_line_a, out_data.x_line_b}) <= 1 &&
      $countones(last_y ^ {out_data.y_line_a, out_data.y_line_b}) <= 1)
    else $error("quadrature phase skipped");

endmodule

bind mouse_quadrature_emulator_top mqe_checker u_mqe_checker (.*);
